FILE: sv/srdm_pkg.sv
// ----------------------------------------------------------------------------
// srdm_pkg: shared types and codes
// Command and result records and kind and status codes for the descriptor manager.
// ----------------------------------------------------------------------------
package srdm_pkg;

  localparam logic [1:0] IN_SEG    = 2'd0;
  localparam logic [1:0] IN_USED   = 2'd1;
  localparam logic [1:0] IN_NOTIFY = 2'd2;

  localparam logic [2:0] OK_DESC   = 3'd0;
  localparam logic [2:0] OK_AVAIL  = 3'd1;
  localparam logic [2:0] OK_CPL    = 3'd2;
  localparam logic [2:0] OK_NOTIFY = 3'd3;
  localparam logic [2:0] OK_ERROR  = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_TOO_BIG  = 3'd2;
  localparam logic [2:0] ST_NO_FREE  = 3'd3;
  localparam logic [2:0] ST_BAD_USED = 3'd4;

  localparam logic [1:0] FLAG_CHAINED  = 2'h1;
  localparam logic [1:0] FLAG_DEVWRITE = 2'h2;

  localparam logic [0:0] REG_QUEUE_SIZE   = 1'd0;
  localparam logic [0:0] REG_QUEUE_NUMBER = 1'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] buf_addr;
    logic [31:0] seg_len;
    logic        device_writes;
    logic [15:0] seg_count;
    logic [15:0] used_id;
    logic [31:0] used_len;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] slot;
    logic [63:0] addr;
    logic [31:0] len;
    logic [1:0]  flags;
    logic [8:0]  next;
    logic [7:0]  head;
    logic [15:0] navail;
    logic [2:0]  status;
    logic        last;
  } res_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [15:0] slot, logic [63:0] addr,
                                  logic [31:0] len, logic [1:0] flags, logic [8:0] next,
                                  logic [7:0] head, logic [15:0] navail,
                                  logic [2:0] status, logic last);
    res_t r;
    r.kind = kind; r.slot = slot; r.addr = addr; r.len = len; r.flags = flags;
    r.next = next; r.head = head; r.navail = navail; r.status = status; r.last = last;
    return r;
  endfunction

endpackage

FILE: sv/split_ring_descriptor_manager_unit.sv
// ----------------------------------------------------------------------------
// split_ring_descriptor_manager_unit: split-ring descriptor manager, driver side
// Allocates descriptors for request segments, posts avail entries, frees chains.
// ----------------------------------------------------------------------------
// Flow: a segment passes the input register and the queue, then EXEC, SEG_RD
//   and SEG_WR, which writes its descriptor result; the last one of a request
//   adds the avail write from AVAIL. Notify and errors answer from EXEC.
//   A completion runs WALK_RD and WALK_WR per freed descriptor, a link table
//   read-modify-write, then CPL. The engine takes one item at a time.
// Reset (rst, synchronous): ring size QSIZE, all descriptors free, indexes zero;
//   the link table reads as its reset order through per-entry valid bits.
module split_ring_descriptor_manager_unit import srdm_pkg::*; #(
  parameter int QSIZE = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [167:0] s_tdata,  // buf_addr, seg_len, device_writes, seg_count,
                                 // used_id, used_len, no_notify, zero pad
  input  logic [1:0]   s_tuser,  // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [151:0] m_tdata,  // slot, out_addr, out_len, desc_flags, desc_next,
                                 // head_id, new_avail_idx, status, zero pad
  output logic [2:0]   m_tuser,  // out_kind
  output logic         m_tlast   // last
);
  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  logic q_valid;
  cmd_t q_cmd;
  res_t res;

  // front: take items and sort out what needs no work
  srdm_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .push, .push_cmd, .full
  );

  // short queue lets the front keep taking items while the engine works
  srdm_queue u_queue (
    .clk, .rst, .push, .push_cmd, .full, .pop, .q_valid, .q_cmd
  );

  // back: free list, tables and the result register
  srdm_back #(.QSIZE(QSIZE)) u_back (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .q_valid, .q_cmd, .pop,
    .m_tvalid, .m_tready, .res
  );

  assign m_tuser = res.kind;
  assign m_tlast = res.last;
  assign m_tdata = {2'b00, res.status, res.navail, res.head, res.next, res.flags,
                    res.len, res.addr, res.slot};
endmodule

FILE: sv/srdm_front.sv
// ----------------------------------------------------------------------------
// srdm_front: input stage
// Registers input items, drops unknown kinds and suppressed notifies.
// ----------------------------------------------------------------------------
module srdm_front import srdm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [167:0] s_tdata,  // buf_addr, seg_len, device_writes, seg_count,
                                 // used_id, used_len, no_notify, zero pad
  input  logic [1:0]   s_tuser,  // kind
  output logic         push,
  output cmd_t         push_cmd,
  input  logic         full
);
  logic fr_valid;
  logic fr_keep;
  cmd_t fr_cmd;
  logic no_notify;

  assign push      = fr_valid && fr_keep && !full;
  assign push_cmd  = fr_cmd;
  assign s_tready  = !fr_valid || !fr_keep || !full;
  assign no_notify = s_tdata[161];

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (s_tready) begin
      fr_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      fr_cmd.kind          <= s_tuser;
      fr_cmd.buf_addr      <= s_tdata[63:0];
      fr_cmd.seg_len       <= s_tdata[95:64];
      fr_cmd.device_writes <= s_tdata[96];
      fr_cmd.seg_count     <= s_tdata[112:97];
      fr_cmd.used_id       <= s_tdata[128:113];
      fr_cmd.used_len      <= s_tdata[160:129];
      fr_keep <= (s_tuser == IN_SEG) || (s_tuser == IN_USED) ||
                 ((s_tuser == IN_NOTIFY) && !no_notify);
    end
  end
endmodule

FILE: sv/srdm_queue.sv
// ----------------------------------------------------------------------------
// srdm_queue: command queue
// Two-entry queue between the input stage and the execution engine.
// ----------------------------------------------------------------------------
module srdm_queue import srdm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);
  cmd_t       ent [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full    = (cnt == 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_cmd   = ent[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
    if (push) ent[wp] <= push_cmd;
  end
endmodule

FILE: sv/srdm_back.sv
// ----------------------------------------------------------------------------
// srdm_back: execution engine
// Owns the free list and descriptor tables and drives the result register.
// ----------------------------------------------------------------------------
module srdm_back import srdm_pkg::*; #(
  parameter int QSIZE = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         q_valid,
  input  cmd_t         q_cmd,
  output logic         pop,
  output logic         m_tvalid,
  input  logic         m_tready,
  output res_t         res
);
  localparam int IW = $clog2(QSIZE);
  localparam int LW = IW + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SEG_RD, S_SEG_WR, S_AVAIL, S_WALK_RD, S_WALK_WR, S_CPL
  } state_t;

  state_t        state;
  cmd_t          cmd;
  logic [LW-1:0] qsize;
  logic [15:0]   qnum;
  logic [LW-1:0] free_head;
  logic [LW-1:0] free_count;
  logic [15:0]   avail_index;
  logic [15:0]   segs_left;
  logic [LW-1:0] request_head;
  logic [2:0]    request_rejected;
  logic [IW-1:0] cur;
  logic [LW-1:0] budget;

  // link memory word: {chain flag, link}
  logic [LW:0]   link_mem [QSIZE];
  logic [63:0]   buf_mem  [QSIZE];
  logic [QSIZE-1:0] vld;
  logic [LW:0]   link_q;
  logic          vld_q;
  logic [63:0]   buf_q;

  logic          ofree;
  logic          mem_we;
  logic [LW:0]   mem_wdata;
  logic [LW-1:0] lnk;
  logic          more;
  logic          chained;
  logic [IW-1:0] lnk_idx;
  logic [IW-1:0] fh_idx;
  logic [IW-1:0] id_idx;
  logic [15:0]   n;
  logic [2:0]    seg_st;
  logic          used_bad;
  logic [15:0]   lnk16;
  logic [15:0]   rh16;
  logic [8:0]    cfg_v;
  logic          cfg_ok;

  assign ofree   = !m_tvalid || m_tready;
  assign lnk     = vld_q ? link_q[LW-1:0] : LW'({1'b0, cur} + 1);
  assign more    = vld_q && link_q[LW];
  assign chained = segs_left > 16'd1;
  assign lnk_idx = (lnk < LW'(QSIZE)) ? lnk[IW-1:0] : '0;
  assign fh_idx  = (free_head < LW'(QSIZE)) ? free_head[IW-1:0] : '0;
  assign id_idx  = IW'(cmd.used_id);
  assign n       = cmd.seg_count;
  assign lnk16   = 16'(lnk);
  assign rh16    = 16'(request_head);
  assign used_bad = (cmd.used_id >= 16'(qsize)) || (free_count >= qsize);
  assign cfg_v   = cfg_data[8:0];
  assign cfg_ok  = cfg_we && (cfg_index == REG_QUEUE_SIZE) && (cfg_v >= 9'd2) &&
                   (32'(cfg_v) <= 32'(QSIZE)) && ((cfg_v & (cfg_v - 9'd1)) == 9'd0);

  always_comb begin
    if (n == 16'd0) seg_st = ST_EMPTY;
    else if (n > 16'(qsize)) seg_st = ST_TOO_BIG;
    else if (n > 16'(free_count)) seg_st = ST_NO_FREE;
    else seg_st = ST_OK;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = {1'b0, free_head};
    if (state == S_SEG_WR && ofree) begin
      mem_we    = 1'b1;
      mem_wdata = {chained, lnk};
    end else if (state == S_WALK_WR) begin
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    link_q <= link_mem[cur];
    vld_q  <= vld[cur];
    if (mem_we) link_mem[cur] <= mem_wdata;
    // a freed descriptor forgets its buffer
    if (state == S_SEG_WR && ofree) buf_mem[cur] <= cmd.buf_addr;
    else if (state == S_WALK_WR) buf_mem[cur] <= '0;
    if (state == S_EXEC) buf_q <= buf_mem[id_idx];
    if (rst || cfg_ok) begin
      vld <= '0;
    end else if (mem_we) begin
      vld[cur] <= 1'b1;
    end
  end

  assign pop = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      m_tvalid         <= 1'b0;
      qsize            <= LW'(QSIZE);
      qnum             <= '0;
      free_head        <= '0;
      free_count       <= LW'(QSIZE);
      avail_index      <= '0;
      segs_left        <= '0;
      request_head     <= '0;
      request_rejected <= '0;
      cur              <= '0;
      budget           <= '0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      if (cfg_ok) begin
        qsize            <= LW'(cfg_v);
        free_head        <= '0;
        free_count       <= LW'(cfg_v);
        avail_index      <= '0;
        segs_left        <= '0;
        request_rejected <= '0;
      end
      if (cfg_we && cfg_index == REG_QUEUE_NUMBER) qnum <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd   <= q_cmd;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd.kind == IN_NOTIFY) begin
            if (ofree) begin
              m_tvalid <= 1'b1;
              res <= mk_res(OK_NOTIFY, qnum, '0, '0, '0, '0, qnum[7:0], '0, ST_OK, 1'b1);
              state <= S_IDLE;
            end
          end else if (cmd.kind == IN_USED) begin
            if (used_bad) begin
              if (ofree) begin
                m_tvalid <= 1'b1;
                res <= mk_res(OK_ERROR, '0, '0, '0, '0, '0, '0, '0, ST_BAD_USED, 1'b1);
                state <= S_IDLE;
              end
            end else begin
              cur    <= id_idx;
              budget <= qsize - free_count;
              state  <= S_WALK_RD;
            end
          end else if (segs_left == 16'd0) begin
            if (seg_st != ST_OK) begin
              if (ofree) begin
                m_tvalid <= 1'b1;
                res <= mk_res(OK_ERROR, '0, '0, '0, '0, '0, '0, '0, seg_st, 1'b1);
                segs_left <= (n == 16'd0) ? 16'd0 : n - 16'd1;
                request_rejected <= (n > 16'd1) ? seg_st : ST_OK;
                state <= S_IDLE;
              end
            end else begin
              segs_left        <= n;
              request_head     <= free_head;
              request_rejected <= ST_OK;
              cur              <= fh_idx;
              state            <= S_SEG_RD;
            end
          end else if (request_rejected != ST_OK) begin
            // drop the rest of a rejected request
            segs_left <= segs_left - 16'd1;
            if (segs_left == 16'd1) request_rejected <= ST_OK;
            state <= S_IDLE;
          end else begin
            cur   <= fh_idx;
            state <= S_SEG_RD;
          end
        end
        S_SEG_RD: state <= S_SEG_WR;
        S_SEG_WR: begin
          if (ofree) begin
            m_tvalid <= 1'b1;
            res <= mk_res(OK_DESC, 16'(cur), cmd.buf_addr, cmd.seg_len,
                          (chained ? FLAG_CHAINED : 2'b00) |
                          (cmd.device_writes ? FLAG_DEVWRITE : 2'b00),
                          lnk16[8:0], '0, '0, ST_OK, chained);
            free_head <= lnk;
            if (free_count != '0) free_count <= free_count - LW'(1);
            segs_left <= segs_left - 16'd1;
            state <= chained ? S_IDLE : S_AVAIL;
          end
        end
        S_AVAIL: begin
          if (ofree) begin
            m_tvalid <= 1'b1;
            res <= mk_res(OK_AVAIL, avail_index & (16'(qsize) - 16'd1), '0, '0, '0, '0,
                          rh16[7:0], avail_index + 16'd1, ST_OK, 1'b1);
            avail_index <= avail_index + 16'd1;
            state <= S_IDLE;
          end
        end
        S_WALK_RD: state <= S_WALK_WR;
        S_WALK_WR: begin
          free_head  <= LW'(cur);
          free_count <= free_count + LW'(1);
          budget     <= budget - LW'(1);
          if (more && budget > LW'(1)) begin
            cur   <= lnk_idx;
            state <= S_WALK_RD;
          end else begin
            state <= S_CPL;
          end
        end
        S_CPL: begin
          if (ofree) begin
            m_tvalid <= 1'b1;
            res <= mk_res(OK_CPL, cmd.used_id, buf_q, cmd.used_len, '0, '0,
                          cmd.used_id[7:0], '0, ST_OK, 1'b1);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= qsize) else $error("free count above ring size");
  a_rej_pending: assert property (@(posedge clk) disable iff (rst)
    (request_rejected != ST_OK) |-> (segs_left != 16'd0))
    else $error("rejected request with nothing left to drop");
  a_walk_budget: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_WR) |-> (budget != '0)) else $error("chain walk past budget");
endmodule

FILE: test/split_ring_descriptor_manager_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// split_ring_descriptor_manager_unit_tb: self-checking bench for the ring manager
// Generates segment, used-element and notify items, predicts every result with
// a behavioral copy of the ring state and compares the output stream in order.
// ----------------------------------------------------------------------------
module split_ring_descriptor_manager_unit_tb;
  import srdm_pkg::*;

  localparam int RING_MAX = 256;

  // one input item, all fields of the slave-side stream
  typedef struct {
    logic [1:0]  kind;
    logic [63:0] addr;
    logic [31:0] len;
    logic        dev_wr;
    logic [15:0] seg_count;
    logic [15:0] used_id;
    logic [31:0] used_len;
    logic        no_notify;
  } ring_item_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         cfg_we;
  logic [0:0]   cfg_index;
  logic [15:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [167:0] s_tdata;   // buf_addr, seg_len, device_writes, seg_count,
                           // used_id, used_len, no_notify, zero pad
  logic [1:0]   s_tuser;   // kind
  logic         m_tvalid;
  logic         m_tready;
  logic [151:0] m_tdata;   // slot, out_addr, out_len, desc_flags, desc_next,
                           // head_id, new_avail_idx, status, zero pad
  logic [2:0]   m_tuser;   // out_kind
  logic         m_tlast;   // last

  split_ring_descriptor_manager_unit #(.QSIZE(RING_MAX)) i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow ring state, advanced when an item is queued for the driver
  // --------------------------------------------------------------------------
  logic [8:0]  link_tbl [RING_MAX];
  bit          chain_tbl[RING_MAX];
  logic [63:0] buf_tbl  [RING_MAX];
  bit          buf_set  [RING_MAX];  // entry written since last ring init
  int          ring_size;
  logic [15:0] queue_num;
  int          free_head, free_cnt, segs_left, req_head;
  bit          rejected;
  logic [15:0] avail_idx, used_cnt;
  int          open_heads[$];       // heads posted to the avail ring, not yet used

  ring_item_t  pending_items[$];
  res_t        expected_results[$];
  int          results_seen;
  bit          failed;

  function automatic void ring_init(int sz);
    ring_size = sz;
    for (int i = 0; i < RING_MAX; i++) begin
      link_tbl[i]  = 9'(i + 1);
      chain_tbl[i] = 1'b0;
      buf_tbl[i]   = '0;
      buf_set[i]   = 1'b0;
    end
    free_head = 0;
    free_cnt  = sz;
    avail_idx = '0;
    used_cnt  = '0;
    segs_left = 0;
    req_head  = 0;
    rejected  = 1'b0;
    open_heads.delete();
  endfunction

  function automatic void push_error(logic [2:0] st);
    expected_results.push_back(res_t'{OK_ERROR, 16'd0, 64'd0, 32'd0, 2'd0, 9'd0, 8'd0,
                                      16'd0, st, 1'b1});
  endfunction

  function automatic void predict_segment(ring_item_t it);
    int          n, idx, nxt;
    logic [2:0]  st;
    bit          chained;
    logic [1:0]  fl;
    logic [15:0] aslot;
    if (segs_left == 0) begin
      n  = it.seg_count;
      st = ST_OK;
      if (n == 0) st = ST_EMPTY;
      else if (n > ring_size) st = ST_TOO_BIG;
      else if (n > free_cnt) st = ST_NO_FREE;
      if (st != ST_OK) begin
        segs_left = (n == 0) ? 0 : n - 1;
        rejected  = (segs_left != 0);
        push_error(st);
        return;
      end
      segs_left = n;
      req_head  = free_head;
      rejected  = 1'b0;
    end else if (rejected) begin
      // drop the rest of a rejected request
      segs_left--;
      if (segs_left == 0) rejected = 1'b0;
      return;
    end
    idx     = (free_head < RING_MAX) ? free_head : 0;
    chained = segs_left > 1;
    fl      = (chained ? FLAG_CHAINED : 2'b00) | (it.dev_wr ? FLAG_DEVWRITE : 2'b00);
    nxt     = link_tbl[idx];
    buf_tbl[idx]   = it.addr;
    buf_set[idx]   = 1'b1;
    chain_tbl[idx] = chained;
    free_head = nxt;
    if (free_cnt > 0) free_cnt--;
    segs_left--;
    expected_results.push_back(res_t'{OK_DESC, 16'(idx), it.addr, it.len, fl, 9'(nxt),
                                      8'd0, 16'd0, ST_OK, !chained ? 1'b0 : 1'b1});
    if (!chained) begin
      aslot     = avail_idx & 16'(ring_size - 1);
      avail_idx = avail_idx + 16'd1;
      expected_results.push_back(res_t'{OK_AVAIL, aslot, 64'd0, 32'd0, 2'd0, 9'd0,
                                        8'(req_head), avail_idx, ST_OK, 1'b1});
      open_heads.push_back(req_head);
    end
  endfunction

  function automatic void predict_used(ring_item_t it);
    int          id, budget, cur, i, nxt;
    bit          more;
    logic [63:0] head_buf;
    id = it.used_id;
    used_cnt = used_cnt + 16'd1;
    if (id >= ring_size || free_cnt >= ring_size) begin
      push_error(ST_BAD_USED);
      return;
    end
    head_buf = buf_tbl[id];
    budget   = ring_size - free_cnt;
    cur      = id;
    // walk the chain back onto the free list, bounded by what is outstanding
    do begin
      i    = (cur < RING_MAX) ? cur : 0;
      nxt  = link_tbl[i];
      more = chain_tbl[i];
      link_tbl[i]  = 9'(free_head);
      buf_tbl[i]   = '0;
      chain_tbl[i] = 1'b0;
      free_head = i;
      free_cnt++;
      budget--;
      cur = nxt;
    end while (more && budget > 0);
    foreach (open_heads[k]) if (open_heads[k] == id) begin
      open_heads.delete(k);
      break;
    end
    expected_results.push_back(res_t'{OK_CPL, 16'(id), head_buf, it.used_len, 2'd0, 9'd0,
                                      8'(id), 16'd0, ST_OK, 1'b1});
  endfunction

  function automatic void queue_item(ring_item_t it);
    case (it.kind)
      IN_SEG:    predict_segment(it);
      IN_USED:   predict_used(it);
      IN_NOTIFY: if (!it.no_notify)
        expected_results.push_back(res_t'{OK_NOTIFY, queue_num, 64'd0, 32'd0, 2'd0,
                                          9'd0, queue_num[7:0], 16'd0, ST_OK, 1'b1});
      default: ;  // unknown kind: ignored
    endcase
    pending_items.push_back(it);
  endfunction

  // --------------------------------------------------------------------------
  // Item builders
  // --------------------------------------------------------------------------
  function automatic ring_item_t noise_item(logic [1:0] kind);
    ring_item_t it;
    it.kind      = kind;
    it.addr      = {$urandom, $urandom};
    it.len       = $urandom;
    it.dev_wr    = $urandom_range(0, 1);
    it.seg_count = $urandom;
    it.used_id   = $urandom;
    it.used_len  = $urandom;
    it.no_notify = $urandom_range(0, 1);
    return it;
  endfunction

  function automatic void add_segment(int count);
    ring_item_t it;
    it = noise_item(IN_SEG);
    it.seg_count = 16'(count);
    queue_item(it);
  endfunction

  function automatic void add_used(int id);
    ring_item_t it;
    it = noise_item(IN_USED);
    it.used_id = 16'(id);
    queue_item(it);
  endfunction

  function automatic void add_bad_used();
    // never point at a live entry that was not written
    if (free_cnt >= ring_size) add_used($urandom_range(0, 65535));
    else add_used($urandom_range(ring_size, 65535));
  endfunction

  function automatic void gen_random(int count);
    int r, n, top;
    for (int made = 0; made < count; made++) begin
      r = $urandom_range(0, 99);
      if (segs_left > 0) begin
        if (r < 85) add_segment($urandom);
        else if (r < 89 && !rejected && buf_set[req_head]) add_used(req_head);
        else if (r < 95) queue_item(noise_item(IN_NOTIFY));
        else queue_item(noise_item(2'd3));
      end else if (r < 7) begin
        queue_item(noise_item(IN_NOTIFY));
      end else if (r < 9) begin
        queue_item(noise_item(2'd3));
      end else if (r < 13) begin
        add_bad_used();
      end else if (open_heads.size() > 0 && (r < 45 || free_cnt == 0)) begin
        add_used(open_heads[$urandom_range(0, open_heads.size() - 1)]);
      end else if (r < 48) begin
        // rejected requests: empty, larger than the ring, more than is free
        case ($urandom_range(0, 2))
          0: add_segment(0);
          1: add_segment(ring_size + $urandom_range(1, 3));
          default: add_segment((free_cnt < ring_size) ? free_cnt + 1 : 0);
        endcase
      end else if (free_cnt > 0) begin
        top = (free_cnt < 6) ? free_cnt : 6;
        n = ($urandom_range(0, 15) == 0) ? free_cnt : $urandom_range(1, top);
        add_segment(n);
      end else begin
        add_bad_used();
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps
  // --------------------------------------------------------------------------
  int burst_left, gap_left;
  ring_item_t cur_item;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      s_tuser    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        s_tdata  <= {6'd0, cur_item.no_notify, cur_item.used_len, cur_item.used_id,
                     cur_item.seg_count, cur_item.dev_wr, cur_item.len, cur_item.addr};
        s_tuser  <= cur_item.kind;
        s_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: own stall pattern, plus one long hold-off to back up the block
  // --------------------------------------------------------------------------
  int       hold_left;
  bit       hold_done;
  bit [7:0] stall_phase;

  always @(posedge clk) begin
    if (rst) begin
      m_tready    <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
      stall_phase <= '0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 150) begin
      m_tready  <= 1'b0;
      hold_left <= 500;
      hold_done <= 1'b1;
    end else begin
      stall_phase <= stall_phase + 8'd1;
      // full-rate stretches alternate with random stalls
      m_tready <= (stall_phase[7:6] == 2'd0) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare each result with the oldest expectation
  // --------------------------------------------------------------------------
  res_t want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("unexpected result, out_kind %0d", m_tuser);
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (m_tuser !== want.kind) begin
          $error("out_kind exp %0d got %0d", want.kind, m_tuser); failed = 1'b1;
        end
        if (m_tdata[15:0] !== want.slot) begin
          $error("slot exp %0h got %0h", want.slot, m_tdata[15:0]); failed = 1'b1;
        end
        if (m_tdata[79:16] !== want.addr) begin
          $error("out_addr exp %0h got %0h", want.addr, m_tdata[79:16]); failed = 1'b1;
        end
        if (m_tdata[111:80] !== want.len) begin
          $error("out_len exp %0h got %0h", want.len, m_tdata[111:80]); failed = 1'b1;
        end
        if (m_tdata[113:112] !== want.flags) begin
          $error("desc_flags exp %0h got %0h", want.flags, m_tdata[113:112]); failed = 1'b1;
        end
        if (m_tdata[122:114] !== want.next) begin
          $error("desc_next exp %0d got %0d", want.next, m_tdata[122:114]); failed = 1'b1;
        end
        if (m_tdata[130:123] !== want.head) begin
          $error("head_id exp %0d got %0d", want.head, m_tdata[130:123]); failed = 1'b1;
        end
        if (m_tdata[146:131] !== want.navail) begin
          $error("new_avail_idx exp %0d got %0d", want.navail, m_tdata[146:131]);
          failed = 1'b1;
        end
        if (m_tdata[149:147] !== want.status) begin
          $error("status exp %0d got %0d", want.status, m_tdata[149:147]); failed = 1'b1;
        end
        if (m_tlast !== want.last) begin
          $error("last exp %0d got %0d", want.last, m_tlast); failed = 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencing: phases separated by idle points where registers are written
  // --------------------------------------------------------------------------
  task automatic wait_drained();
    while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    // let dropped segments and long chain walks settle
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] data);
    int v;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_QUEUE_SIZE) begin
      v = data[8:0];
      if (v >= 2 && v <= RING_MAX && (v & (v - 1)) == 0) ring_init(v);
    end else begin
      queue_num = data;
    end
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int h1, h3;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    failed = 1'b0;
    results_seen = 0;
    queue_num = '0;
    ring_init(RING_MAX);
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: notify both ways, unknown kind, bad used ids, empty request,
    // field extremes, a chained request and its completion
    queue_item(noise_item(IN_NOTIFY));
    pending_items[$].no_notify = 1'b0;
    expected_results.delete();
    expected_results.push_back(res_t'{OK_NOTIFY, 16'd0, 64'd0, 32'd0, 2'd0, 9'd0, 8'd0,
                                      16'd0, ST_OK, 1'b1});
    begin
      ring_item_t it;
      it = noise_item(IN_NOTIFY);
      it.no_notify = 1'b1;
      queue_item(it);
      queue_item(noise_item(2'd3));
      add_used(0);
      add_segment(0);
      h1 = free_head;
      it = noise_item(IN_SEG);
      it.seg_count = 16'd1; it.addr = '1; it.len = '1; it.dev_wr = 1'b1;
      queue_item(it);
      h3 = free_head;
      it = noise_item(IN_SEG);
      it.seg_count = 16'd3; it.addr = '0; it.len = '0; it.dev_wr = 1'b0;
      queue_item(it);
      add_segment(16'hFFFF);
      add_segment(16'h0000);
      add_used(300);
      add_used(16'hFFFF);
      add_used(h3);
      add_used(h1);
      add_segment(257);
    end
    gen_random(250);
    wait_drained();

    write_reg(REG_QUEUE_SIZE, 16'd2);
    write_reg(REG_QUEUE_NUMBER, 16'hFFFF);
    end_writes();
    gen_random(220);
    wait_drained();

    write_reg(REG_QUEUE_SIZE, 16'h0203);   // not a power of two: ignored
    write_reg(REG_QUEUE_SIZE, 16'h0200);   // reads as zero: ignored
    write_reg(REG_QUEUE_SIZE, 16'd16);
    write_reg(REG_QUEUE_NUMBER, 16'($urandom));
    end_writes();
    gen_random(220);
    wait_drained();

    write_reg(REG_QUEUE_SIZE, 16'd4);
    end_writes();
    gen_random(220);
    wait_drained();

    write_reg(REG_QUEUE_SIZE, 16'd256);
    write_reg(REG_QUEUE_NUMBER, 16'd0);
    end_writes();
    gen_random(220);
    wait_drained();

    write_reg(REG_QUEUE_SIZE, 16'd64);
    write_reg(REG_QUEUE_NUMBER, 16'($urandom));
    end_writes();
    gen_random(220);
    wait_drained();

    if (!failed) begin
      $display("split_ring_descriptor_manager_unit_tb OK");
    end else begin
      $display("split_ring_descriptor_manager_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("split_ring_descriptor_manager_unit_tb NOT OK");
    $finish;
  end

endmodule
